>>> hw/rtl/bgi_pkg.sv
package bgi_pkg;

  localparam int unsigned MAX_X_POINTS = 16;
  localparam int unsigned MAX_Y_POINTS = 16;

  localparam int unsigned XAW = $clog2(MAX_X_POINTS);
  localparam int unsigned YAW = $clog2(MAX_Y_POINTS);
  localparam int unsigned IW  = (XAW > YAW) ? XAW : YAW;
  localparam int unsigned GAW = $clog2(MAX_X_POINTS * MAX_Y_POINTS);

  localparam int unsigned CNT_W     = 5;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned DIFF_W    = DATA_W + 1;
  localparam int unsigned PROD_W    = DIFF_W + DATA_W;
  localparam int unsigned ACC_W     = PROD_W + 1;
  localparam int unsigned DIV_STEPS = ACC_W;
  localparam int unsigned DCNT_W    = $clog2(DIV_STEPS);

  localparam logic [CFG_IDX_W-1:0] CFG_X_POINTS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_POINTS = 2'd1;

  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_ZERO_WIDTH = 2'd1;
  localparam logic [1:0] ST_SAT        = 2'd2;

  typedef enum logic [1:0] {
    OP_QUERY = 2'd0,
    OP_WR_X  = 2'd1,
    OP_WR_Y  = 2'd2,
    OP_WR_Z  = 2'd3
  } op_e;

  typedef enum logic [3:0] {
    RD_NONE, RD_FIRST, RD_LAST, RD_IDX, RD_LEFT, RD_RIGHT,
    RD_Z00, RD_Z01, RD_Z10, RD_Z11
  } rd_sel_e;

  typedef enum logic [3:0] {
    CAP_NONE, CAP_FIRST, CAP_INC, CAP_LEFT, CAP_P1, CAP_P2,
    CAP_Z00, CAP_Z01, CAP_Z10, CAP_Z11
  } cap_e;

  typedef enum logic [3:0] {
    DP_NONE, DP_MUL_A, DP_MUL_B, DP_SUM, DP_DIV_INIT, DP_DIV_STEP, DP_DIV_END,
    DP_OUT_WR, DP_OUT_DEG, DP_OUT_RES
  } dp_op_e;

  typedef enum logic [1:0] {
    JOB_R1, JOB_R2, JOB_FIN
  } job_e;

  typedef struct packed {
    logic    accept;
    logic    axis;     // 0: x, 1: y
    rd_sel_e rd_sel;
    cap_e    cap;
    logic    idx_inc;
    dp_op_e  op;
    job_e    job;
  } cmd_t;

  typedef struct packed {
    logic srch_end;
    logic hit;
    logic degen;
    logic div_last;
  } stat_t;

endpackage

>>> hw/rtl/bgi_ram.sv
module bgi_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> hw/rtl/bgi_datapath.sv
module bgi_datapath import bgi_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cmd_t                 cmd_i,
  output stat_t                stat_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CNT_W-1:0]     cfg_data_i,
  input  logic [1:0]           operation_i,
  input  logic [3:0]           column_index_i,
  input  logic [3:0]           row_index_i,
  input  logic signed [31:0]   write_value_i,
  input  logic signed [31:0]   point_x_i,
  input  logic signed [31:0]   point_y_i,
  output logic signed [31:0]   interpolated_o,
  output logic [1:0]           status_o
);

  logic [CNT_W-1:0] xcnt_q, ycnt_q, nx, ny;
  logic [XAW-1:0]   nxm1, left_x_q, x_raddr;
  logic [YAW-1:0]   nym1, left_y_q, y_raddr;
  logic [IW-1:0]    idx_q;
  logic [GAW-1:0]   g_raddr, g_waddr;
  logic [XAW-1:0]   gx;
  logic [YAW-1:0]   gy;
  logic             x_we, y_we, g_we, col_ok, row_ok;

  logic signed [DATA_W-1:0] x_rdata, y_rdata, g_rdata, bp_rdata, key;
  logic signed [DATA_W-1:0] px_q, py_q, first_q;
  logic signed [DATA_W-1:0] p1x_q, p2x_q, p1y_q, p2y_q;
  logic signed [DATA_W-1:0] z00_q, z01_q, z10_q, z11_q, r1_q, r2_q, res_q;
  logic                     inc_q, sat_q;

  logic signed [DATA_W-1:0] p1, p2, v, qa, qb;
  logic signed [DIFF_W-1:0] diff_a, diff_b, den;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [ACC_W-1:0]  acc_q;

  logic [ACC_W-1:0]  numm_q;
  logic [DIFF_W-1:0] dmag_q, quo_q, lim, mag;
  logic [DIFF_W:0]   rem_sh;
  logic [DIFF_W-1:0] rem_q;
  logic              neg_q, ovf_q, qbit, dsat;
  logic [DCNT_W-1:0] dcnt_q;
  logic signed [DATA_W-1:0] divres;

  logic signed [DATA_W-1:0] interp_q;
  logic [1:0]               stat_q;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      xcnt_q <= CNT_W'(2);
      ycnt_q <= CNT_W'(2);
    end else if (cfg_we_i) begin
      if (cfg_index_i == CFG_X_POINTS) xcnt_q <= cfg_data_i;
      if (cfg_index_i == CFG_Y_POINTS) ycnt_q <= cfg_data_i;
    end
  end

  always_comb begin
    nx = xcnt_q;
    if (xcnt_q < CNT_W'(2)) nx = CNT_W'(2);
    else if (32'(xcnt_q) > MAX_X_POINTS) nx = CNT_W'(MAX_X_POINTS);
    ny = ycnt_q;
    if (ycnt_q < CNT_W'(2)) ny = CNT_W'(2);
    else if (32'(ycnt_q) > MAX_Y_POINTS) ny = CNT_W'(MAX_Y_POINTS);
  end

  assign nxm1 = XAW'(nx - CNT_W'(1));
  assign nym1 = YAW'(ny - CNT_W'(1));

  // Write path, taken on the accepting cycle
  assign col_ok  = 32'(column_index_i) < MAX_X_POINTS;
  assign row_ok  = 32'(row_index_i) < MAX_Y_POINTS;
  assign x_we    = cmd_i.accept && (operation_i == OP_WR_X) && col_ok;
  assign y_we    = cmd_i.accept && (operation_i == OP_WR_Y) && row_ok;
  assign g_we    = cmd_i.accept && (operation_i == OP_WR_Z) && col_ok && row_ok;
  assign g_waddr = GAW'(GAW'(row_index_i) * GAW'(MAX_X_POINTS) + GAW'(column_index_i));

  // Read addresses
  always_comb begin
    x_raddr = '0;
    y_raddr = '0;
    gx      = left_x_q;
    gy      = left_y_q;
    case (cmd_i.rd_sel)
      RD_LAST: begin
        x_raddr = nxm1;
        y_raddr = nym1;
      end
      RD_IDX: begin
        x_raddr = XAW'(idx_q);
        y_raddr = YAW'(idx_q);
      end
      RD_LEFT: begin
        x_raddr = left_x_q;
        y_raddr = left_y_q;
      end
      RD_RIGHT: begin
        x_raddr = left_x_q + XAW'(1);
        y_raddr = left_y_q + YAW'(1);
      end
      RD_Z01: gx = left_x_q + XAW'(1);
      RD_Z10: gy = left_y_q + YAW'(1);
      RD_Z11: begin
        gx = left_x_q + XAW'(1);
        gy = left_y_q + YAW'(1);
      end
      default: ;
    endcase
  end

  assign g_raddr = GAW'(GAW'(gy) * GAW'(MAX_X_POINTS) + GAW'(gx));

  bgi_ram #(.Width(DATA_W), .Depth(MAX_X_POINTS)) u_x_ram (
    .clk_i, .we_i(x_we), .waddr_i(XAW'(column_index_i)), .wdata_i(write_value_i),
    .raddr_i(x_raddr), .rdata_o(x_rdata)
  );

  bgi_ram #(.Width(DATA_W), .Depth(MAX_Y_POINTS)) u_y_ram (
    .clk_i, .we_i(y_we), .waddr_i(YAW'(row_index_i)), .wdata_i(write_value_i),
    .raddr_i(y_raddr), .rdata_o(y_rdata)
  );

  bgi_ram #(.Width(DATA_W), .Depth(MAX_X_POINTS * MAX_Y_POINTS)) u_grid_ram (
    .clk_i, .we_i(g_we), .waddr_i(g_waddr), .wdata_i(write_value_i),
    .raddr_i(g_raddr), .rdata_o(g_rdata)
  );

  assign bp_rdata = cmd_i.axis ? y_rdata : x_rdata;
  assign key      = cmd_i.axis ? py_q : px_q;

  // Operand selection per interpolation job
  always_comb begin
    p1 = p1x_q;
    p2 = p2x_q;
    v  = px_q;
    qa = z00_q;
    qb = z01_q;
    case (cmd_i.job)
      JOB_R2: begin
        qa = z10_q;
        qb = z11_q;
      end
      JOB_FIN: begin
        p1 = p1y_q;
        p2 = p2y_q;
        v  = py_q;
        qa = r1_q;
        qb = r2_q;
      end
      default: ;
    endcase
  end

  assign diff_a = DIFF_W'(p2) - DIFF_W'(v);
  assign diff_b = DIFF_W'(v) - DIFF_W'(p1);
  assign den    = DIFF_W'(p2) - DIFF_W'(p1);

  // Restoring divide, one quotient bit per cycle
  assign rem_sh = {rem_q, numm_q[ACC_W-1]};
  assign qbit   = rem_sh >= {1'b0, dmag_q};
  assign lim    = neg_q ? DIFF_W'(33'h0_8000_0000) : DIFF_W'(33'h0_7fff_ffff);
  assign dsat   = ovf_q || (quo_q > lim);
  assign mag    = dsat ? lim : quo_q;
  assign divres = neg_q ? DATA_W'(-mag) : mag[DATA_W-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      px_q  <= point_x_i;
      py_q  <= point_y_i;
      sat_q <= 1'b0;
    end

    case (cmd_i.cap)
      CAP_FIRST: first_q <= bp_rdata;
      CAP_INC: begin
        inc_q <= bp_rdata > first_q;
        idx_q <= IW'(1);
      end
      CAP_LEFT: begin
        if (cmd_i.axis) left_y_q <= YAW'(idx_q - IW'(1));
        else            left_x_q <= XAW'(idx_q - IW'(1));
      end
      CAP_P1: begin
        if (cmd_i.axis) p1y_q <= bp_rdata;
        else            p1x_q <= bp_rdata;
      end
      CAP_P2: begin
        if (cmd_i.axis) p2y_q <= bp_rdata;
        else            p2x_q <= bp_rdata;
      end
      CAP_Z00: z00_q <= g_rdata;
      CAP_Z01: z01_q <= g_rdata;
      CAP_Z10: z10_q <= g_rdata;
      CAP_Z11: z11_q <= g_rdata;
      default: ;
    endcase

    if (cmd_i.idx_inc) idx_q <= idx_q + IW'(1);

    case (cmd_i.op)
      DP_MUL_A: prod_q <= diff_a * qa;
      DP_MUL_B: begin
        acc_q  <= ACC_W'(prod_q);
        prod_q <= diff_b * qb;
      end
      DP_SUM: acc_q <= acc_q + ACC_W'(prod_q);
      DP_DIV_INIT: begin
        numm_q <= acc_q[ACC_W-1] ? ACC_W'(-acc_q) : acc_q;
        dmag_q <= den[DIFF_W-1] ? DIFF_W'(-den) : den;
        neg_q  <= acc_q[ACC_W-1] ^ den[DIFF_W-1];
        rem_q  <= '0;
        quo_q  <= '0;
        ovf_q  <= 1'b0;
        dcnt_q <= '0;
      end
      DP_DIV_STEP: begin
        rem_q  <= qbit ? DIFF_W'(rem_sh - {1'b0, dmag_q}) : DIFF_W'(rem_sh);
        numm_q <= numm_q << 1;
        quo_q  <= {quo_q[DIFF_W-2:0], qbit};
        ovf_q  <= ovf_q | quo_q[DIFF_W-1];
        dcnt_q <= dcnt_q + DCNT_W'(1);
      end
      DP_DIV_END: begin
        if (dsat) sat_q <= 1'b1;
        case (cmd_i.job)
          JOB_R1:  r1_q  <= divres;
          JOB_R2:  r2_q  <= divres;
          default: res_q <= divres;
        endcase
      end
      DP_OUT_WR: begin
        interp_q <= '0;
        stat_q   <= ST_OK;
      end
      DP_OUT_DEG: begin
        interp_q <= '0;
        stat_q   <= ST_ZERO_WIDTH;
      end
      DP_OUT_RES: begin
        interp_q <= res_q;
        stat_q   <= sat_q ? ST_SAT : ST_OK;
      end
      default: ;
    endcase
  end

  assign stat_o.srch_end = cmd_i.axis ? (idx_q == IW'(nym1)) : (idx_q == IW'(nxm1));
  assign stat_o.hit      = inc_q ? (key <= bp_rdata) : (key >= bp_rdata);
  assign stat_o.degen    = (p1x_q == p2x_q) || (p1y_q == p2y_q);
  assign stat_o.div_last = dcnt_q == DCNT_W'(DIV_STEPS - 1);

  assign interpolated_o = interp_q;
  assign status_o       = stat_q;

endmodule

>>> hw/rtl/bgi_ctrl.sv
module bgi_ctrl import bgi_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [1:0] operation_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output cmd_t       cmd_o,
  input  stat_t      stat_i
);

  typedef enum logic [4:0] {
    S_IDLE, S_AX_FIRST, S_AX_LAST, S_AX_INC, S_SRCH_RD, S_SRCH_CMP,
    S_P1, S_P2, S_P3, S_Z0, S_Z1, S_Z2, S_Z3, S_Z4,
    S_MUL_A, S_MUL_B, S_SUM, S_DIV_INIT, S_DIV_STEP, S_DIV_END,
    S_OUT_DEG, S_OUT_RES
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_free, accept, load;
  logic   axis_q, axis_d;
  job_e   job_q, job_d;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE) && out_free;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d       = state_q;
    axis_d        = axis_q;
    job_d         = job_q;
    load          = 1'b0;
    cmd_o         = '0;
    cmd_o.axis    = axis_q;
    cmd_o.job     = job_q;
    cmd_o.rd_sel  = RD_NONE;
    cmd_o.cap     = CAP_NONE;
    cmd_o.op      = DP_NONE;
    cmd_o.accept  = accept;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (operation_i == OP_QUERY) begin
            axis_d  = 1'b0;
            state_d = S_AX_FIRST;
          end else begin
            cmd_o.op = DP_OUT_WR;
            load     = 1'b1;
          end
        end
      end
      S_AX_FIRST: begin
        cmd_o.rd_sel = RD_FIRST;
        state_d      = S_AX_LAST;
      end
      S_AX_LAST: begin
        cmd_o.rd_sel = RD_LAST;
        cmd_o.cap    = CAP_FIRST;
        state_d      = S_AX_INC;
      end
      S_AX_INC: begin
        cmd_o.cap = CAP_INC;
        state_d   = S_SRCH_RD;
      end
      S_SRCH_RD: begin
        // ran off the end of the list: use the last segment
        if (stat_i.srch_end) begin
          cmd_o.cap = CAP_LEFT;
          state_d   = S_P1;
        end else begin
          cmd_o.rd_sel = RD_IDX;
          state_d      = S_SRCH_CMP;
        end
      end
      S_SRCH_CMP: begin
        if (stat_i.hit) begin
          cmd_o.cap = CAP_LEFT;
          state_d   = S_P1;
        end else begin
          cmd_o.idx_inc = 1'b1;
          state_d       = S_SRCH_RD;
        end
      end
      S_P1: begin
        cmd_o.rd_sel = RD_LEFT;
        state_d      = S_P2;
      end
      S_P2: begin
        cmd_o.rd_sel = RD_RIGHT;
        cmd_o.cap    = CAP_P1;
        state_d      = S_P3;
      end
      S_P3: begin
        cmd_o.cap = CAP_P2;
        if (axis_q) begin
          state_d = S_Z0;
        end else begin
          axis_d  = 1'b1;
          state_d = S_AX_FIRST;
        end
      end
      S_Z0: begin
        cmd_o.rd_sel = RD_Z00;
        state_d      = S_Z1;
      end
      S_Z1: begin
        cmd_o.rd_sel = RD_Z01;
        cmd_o.cap    = CAP_Z00;
        state_d      = S_Z2;
      end
      S_Z2: begin
        cmd_o.rd_sel = RD_Z10;
        cmd_o.cap    = CAP_Z01;
        state_d      = S_Z3;
      end
      S_Z3: begin
        cmd_o.rd_sel = RD_Z11;
        cmd_o.cap    = CAP_Z10;
        state_d      = S_Z4;
      end
      S_Z4: begin
        cmd_o.cap = CAP_Z11;
        job_d     = JOB_R1;
        state_d   = stat_i.degen ? S_OUT_DEG : S_MUL_A;
      end
      S_MUL_A: begin
        cmd_o.op = DP_MUL_A;
        state_d  = S_MUL_B;
      end
      S_MUL_B: begin
        cmd_o.op = DP_MUL_B;
        state_d  = S_SUM;
      end
      S_SUM: begin
        cmd_o.op = DP_SUM;
        state_d  = S_DIV_INIT;
      end
      S_DIV_INIT: begin
        cmd_o.op = DP_DIV_INIT;
        state_d  = S_DIV_STEP;
      end
      S_DIV_STEP: begin
        cmd_o.op = DP_DIV_STEP;
        if (stat_i.div_last) state_d = S_DIV_END;
      end
      S_DIV_END: begin
        cmd_o.op = DP_DIV_END;
        case (job_q)
          JOB_R1: begin
            job_d   = JOB_R2;
            state_d = S_MUL_A;
          end
          JOB_R2: begin
            job_d   = JOB_FIN;
            state_d = S_MUL_A;
          end
          default: state_d = S_OUT_RES;
        endcase
      end
      S_OUT_DEG: begin
        if (out_free) begin
          cmd_o.op = DP_OUT_DEG;
          load     = 1'b1;
          state_d  = S_IDLE;
        end
      end
      S_OUT_RES: begin
        if (out_free) begin
          cmd_o.op = DP_OUT_RES;
          load     = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      axis_q      <= 1'b0;
      job_q       <= JOB_R1;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      axis_q  <= axis_d;
      job_q   <= job_d;
      if (load)             out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

>>> hw/rtl/bilinear_grid_interpolator_core.sv
// Bilinear lookup over a grid of up to 16 x 16 signed Q16.16 values with
// x and y breakpoint lists (increasing or decreasing). A write transaction
// (x breakpoint, y breakpoint or grid value) returns zero with status ok
// in the cycle after it is accepted. A query runs an entry-by-entry search
// on each axis, four grid reads, then three interpolations, each of which
// ends in a 66-step restoring divider that resolves one quotient bit per
// cycle; that divider sets the query time. Points outside a list are
// extrapolated from the end segment; status 1 flags a zero-width segment,
// status 2 a saturated result. Every store entry a query touches must
// have been written first.
module bilinear_grid_interpolator_core import bgi_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [1:0]           operation_i,
  input  logic [3:0]           column_index_i,
  input  logic [3:0]           row_index_i,
  input  logic signed [31:0]   write_value_i,
  input  logic signed [31:0]   point_x_i,
  input  logic signed [31:0]   point_y_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic signed [31:0]   interpolated_o,
  output logic [1:0]           status_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CNT_W-1:0]     cfg_data_i
);

  cmd_t  cmd;
  stat_t stat;

  assign cfg_ready_o = 1'b1;

  bgi_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .operation_i,
    .in_ready_o,
    .out_valid_o,
    .out_ready_i,
    .cmd_o  (cmd),
    .stat_i (stat)
  );

  bgi_datapath u_dp (
    .clk_i,
    .rst_ni,
    .cmd_i       (cmd),
    .stat_o      (stat),
    .cfg_we_i    (cfg_valid_i),
    .cfg_index_i,
    .cfg_data_i,
    .operation_i,
    .column_index_i,
    .row_index_i,
    .write_value_i,
    .point_x_i,
    .point_y_i,
    .interpolated_o,
    .status_o
  );

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |-> !out_valid_o || out_ready_i)
    else $error("transaction accepted while result slot blocked");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o != 2'd3)
    else $error("undefined status code");

  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_ZERO_WIDTH |-> interpolated_o == '0)
    else $error("zero-width segment with nonzero result");

  a_write_fast: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && operation_i != OP_QUERY |=> out_valid_o)
    else $error("write transaction did not return a result");

endmodule

>>> test/bilinear_grid_interpolator_core_tb.sv
module bilinear_grid_interpolator_core_tb;
  import bgi_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 4000000;

  typedef struct {
    op_e               op;
    logic [3:0]        col;
    logic [3:0]        row;
    logic signed [31:0] wval;
    logic signed [31:0] px;
    logic signed [31:0] py;
  } lookup_req_t;

  typedef struct {
    logic signed [31:0] value;
    logic [1:0]         status;
  } lookup_rsp_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [1:0] operation_i = '0;
  logic [3:0] column_index_i = '0;
  logic [3:0] row_index_i = '0;
  logic signed [31:0] write_value_i = '0;
  logic signed [31:0] point_x_i = '0;
  logic signed [31:0] point_y_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [31:0] interpolated_o;
  logic [1:0] status_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CNT_W-1:0] cfg_data_i = '0;

  bilinear_grid_interpolator_core dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // shadow copy of the block's stores and registers
  logic signed [31:0] x_bp [MAX_X_POINTS];
  logic signed [31:0] y_bp [MAX_Y_POINTS];
  logic signed [31:0] grid [MAX_X_POINTS*MAX_Y_POINTS];
  logic [CNT_W-1:0] x_count = 5'd2;
  logic [CNT_W-1:0] y_count = 5'd2;

  lookup_req_t pending_reqs[$];
  lookup_rsp_t expected_rsps[$];
  lookup_req_t cur_req;
  int errors = 0;
  int unsigned cycles = 0;
  int in_idle = 0;
  int out_idle = 0;
  bit calm = 1'b0;

  function automatic logic signed [31:0] lerp_segment(input logic signed [31:0] p1,
      input logic signed [31:0] p2, input logic signed [31:0] v,
      input logic signed [31:0] qa, input logic signed [31:0] qb, inout bit sat);
    logic signed [127:0] a1, a2, av, aqa, aqb, num, den, q;
    a1 = 128'(p1); a2 = 128'(p2); av = 128'(v); aqa = 128'(qa); aqb = 128'(qb);
    num = (a2 - av) * aqa + (av - a1) * aqb;
    den = a2 - a1;
    q = num / den;
    if (q > 128'sd2147483647) begin
      sat = 1'b1;
      return 32'sh7fffffff;
    end
    if (q < -128'sd2147483648) begin
      sat = 1'b1;
      return 32'sh80000000;
    end
    return q[31:0];
  endfunction

  function automatic int left_segment(input logic signed [31:0] bp [16], input int n,
      input logic signed [31:0] key);
    bit rising;
    int i;
    rising = bp[n-1] > bp[0];
    for (i = 1; i < n - 1; i++) begin
      if (rising ? (key <= bp[i]) : (key >= bp[i])) break;
    end
    return i - 1;
  endfunction

  function automatic int used_count(input logic [CNT_W-1:0] c, input int maxn);
    if (c < 2) return 2;
    if (c > maxn) return maxn;
    return c;
  endfunction

  function automatic lookup_rsp_t apply_lookup(input lookup_req_t r);
    lookup_rsp_t rsp;
    int x1, y1;
    bit sat;
    logic signed [31:0] r1, r2;
    rsp.value = '0;
    rsp.status = ST_OK;
    sat = 1'b0;
    case (r.op)
      OP_WR_X: x_bp[r.col] = r.wval;
      OP_WR_Y: y_bp[r.row] = r.wval;
      OP_WR_Z: grid[r.row*MAX_X_POINTS + r.col] = r.wval;
      default: begin
        x1 = left_segment(x_bp, used_count(x_count, MAX_X_POINTS), r.px);
        y1 = left_segment(y_bp, used_count(y_count, MAX_Y_POINTS), r.py);
        if (x_bp[x1] == x_bp[x1+1] || y_bp[y1] == y_bp[y1+1]) begin
          rsp.status = ST_ZERO_WIDTH;
        end else begin
          r1 = lerp_segment(x_bp[x1], x_bp[x1+1], r.px, grid[y1*MAX_X_POINTS + x1],
                            grid[y1*MAX_X_POINTS + x1 + 1], sat);
          r2 = lerp_segment(x_bp[x1], x_bp[x1+1], r.px, grid[(y1+1)*MAX_X_POINTS + x1],
                            grid[(y1+1)*MAX_X_POINTS + x1 + 1], sat);
          rsp.value = lerp_segment(y_bp[y1], y_bp[y1+1], r.py, r1, r2, sat);
          rsp.status = sat ? ST_SAT : ST_OK;
        end
      end
    endcase
    return rsp;
  endfunction

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) expected_rsps.push_back(apply_lookup(cur_req));
      if (!in_valid_i || in_ready_o) begin
        if (in_idle > 0) begin
          in_idle--;
          in_valid_i <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          cur_req = pending_reqs.pop_front();
          operation_i <= cur_req.op;
          column_index_i <= cur_req.col;
          row_index_i <= cur_req.row;
          write_value_i <= cur_req.wval;
          point_x_i <= cur_req.px;
          point_y_i <= cur_req.py;
          in_valid_i <= 1'b1;
          if (!calm && $urandom_range(0, 9) == 0) in_idle = $urandom_range(1, 11);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // response monitor
  always @(posedge clk_i or negedge rst_ni) begin
    lookup_rsp_t exp_rsp;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (expected_rsps.size() == 0) begin
          $error("unexpected result: interpolated %0d status %0d", interpolated_o, status_o);
          errors++;
        end else begin
          exp_rsp = expected_rsps.pop_front();
          if (interpolated_o !== exp_rsp.value) begin
            $error("interpolated: expected %0d, actual %0d", exp_rsp.value, interpolated_o);
            errors++;
          end
          if (status_o !== exp_rsp.status) begin
            $error("status: expected %0d, actual %0d", exp_rsp.status, status_o);
            errors++;
          end
        end
      end
      if (out_idle > 0) begin
        out_idle--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        if (!calm && $urandom_range(0, 7) == 0) out_idle = $urandom_range(1, 11);
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic logic signed [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return $signed($urandom_range(0, 32'h0003ffff)) - 32'sh00020000;
      3: return $signed($urandom_range(0, 32'h0fffffff)) - 32'sh08000000;
      default: return $urandom;
    endcase
  endfunction

  task automatic push_req(input op_e op, input int col, input int row,
      input logic signed [31:0] wval, input logic signed [31:0] px,
      input logic signed [31:0] py);
    lookup_req_t r;
    r.op = op;
    r.col = 4'(col);
    r.row = 4'(row);
    r.wval = wval;
    r.px = px;
    r.py = py;
    pending_reqs.push_back(r);
  endtask

  task automatic wait_drained();
    do @(posedge clk_i);
    while (pending_reqs.size() > 0 || in_valid_i || expected_rsps.size() > 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CNT_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    if (idx == CFG_X_POINTS) x_count = data;
    else if (idx == CFG_Y_POINTS) y_count = data;
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // loads a whole breakpoint list: rising, falling, with repeats, scattered, or rising then falling
  task automatic load_axis(input op_e op);
    longint v, stride;
    int shape;
    shape = $urandom_range(0, 4);
    v = $signed($urandom_range(0, 32'h3fffffff)) - 64'sh20000000;
    for (int i = 0; i < 16; i++) begin
      if (shape == 3) v = rand_word();
      push_req(op, i, i, v[31:0], $urandom, $urandom);
      stride = $urandom_range(1, 1 << $urandom_range(0, 22));
      if (shape == 2 && $urandom_range(0, 3) == 0) stride = 0;
      v = (shape == 1 || shape == 4 && i > 7) ? v - stride : v + stride;
    end
  endtask

  function automatic logic signed [31:0] near_point(input logic signed [31:0] bp [16]);
    case ($urandom_range(0, 3))
      0: return rand_word();
      1: return bp[$urandom_range(0, 15)];
      default: return bp[$urandom_range(0, 15)] + $signed($urandom_range(0, 4095)) - 2048;
    endcase
  endfunction

  initial begin
    logic signed [31:0] xs [16];
    logic signed [31:0] ys [16];
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // every store entry is written before any query reads it
    for (int i = 0; i < 16; i++) begin
      push_req(OP_WR_X, i, 0, i * 32'sh00010000, 0, 0);
      push_req(OP_WR_Y, 0, i, i * 32'sh00010000, 0, 0);
    end
    for (int r = 0; r < 16; r++)
      for (int c = 0; c < 16; c++)
        push_req(OP_WR_Z, c, r, rand_word(), 0, 0);

    // directed: bounds, extrapolation, saturation, flat and falling segments
    push_req(OP_QUERY, 0, 0, 0, 32'sh00008000, 32'sh00008000);
    push_req(OP_QUERY, 15, 15, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
    push_req(OP_QUERY, 0, 0, 32'sh80000000, 32'sh80000000, 32'sh80000000);
    push_req(OP_WR_Z, 0, 0, 32'sh7fffffff, 0, 0);
    push_req(OP_WR_Z, 1, 0, 32'sh80000000, 0, 0);
    push_req(OP_WR_Z, 0, 1, 32'sh80000000, 0, 0);
    push_req(OP_WR_Z, 1, 1, 32'sh7fffffff, 0, 0);
    push_req(OP_QUERY, 0, 0, 0, 32'sh00004000, 32'sh0000c000);
    push_req(OP_QUERY, 0, 0, 0, 32'sh7fffffff, 32'sh00000000);
    push_req(OP_QUERY, 0, 0, 0, 32'sh80000000, 32'sh80000000);
    push_req(OP_WR_X, 1, 0, 32'sh00000000, 0, 0);
    push_req(OP_QUERY, 0, 0, 0, 32'sh00001234, 32'sh00005678);
    push_req(OP_WR_X, 1, 0, 32'sh7fffffff, 0, 0);
    push_req(OP_WR_X, 0, 0, 32'sh80000000, 0, 0);
    push_req(OP_QUERY, 0, 0, 0, 32'sh00000001, 32'shffff0000);
    push_req(OP_WR_Y, 0, 0, 32'sh00050000, 0, 0);
    push_req(OP_WR_Y, 0, 1, 32'shfffb0000, 0, 0);
    push_req(OP_QUERY, 0, 0, 0, 32'sh00000000, 32'sh00010000);
    push_req(OP_WR_Y, 15, 15, 32'sh7fffffff, 0, 0);
    push_req(OP_WR_Z, 15, 15, 32'sh80000000, 0, 0);
    wait_drained();

    write_reg(2'd3, 5'd7);
    for (int ph = 0; ph < 9; ph++) begin
      calm = (ph >= 7);
      case (ph)
        0: begin write_reg(CFG_X_POINTS, 5'd16); write_reg(CFG_Y_POINTS, 5'd16); end
        1: begin write_reg(CFG_X_POINTS, 5'd2); write_reg(CFG_Y_POINTS, 5'd2); end
        2: begin write_reg(CFG_X_POINTS, 5'd0); write_reg(CFG_Y_POINTS, 5'd31); end
        3: begin write_reg(CFG_X_POINTS, 5'd1); write_reg(CFG_Y_POINTS, 5'd17); end
        default: begin
          write_reg(CFG_X_POINTS, CNT_W'($urandom_range(2, 16)));
          write_reg(CFG_Y_POINTS, CNT_W'($urandom_range(0, 31)));
        end
      endcase
      load_axis(OP_WR_X);
      load_axis(OP_WR_Y);
      wait_drained();
      xs = x_bp;
      ys = y_bp;
      for (int k = 0; k < 30; k++) begin
        case ($urandom_range(0, 9))
          0, 1: push_req(OP_WR_Z, $urandom_range(0, 15), $urandom_range(0, 15),
                         rand_word(), $urandom, $urandom);
          2: push_req(op_e'($urandom_range(0, 1) ? OP_WR_X : OP_WR_Y),
                      $urandom_range(0, 15), $urandom_range(0, 15), near_point(xs),
                      $urandom, $urandom);
          default: push_req(OP_QUERY, $urandom_range(0, 15), $urandom_range(0, 15),
                            $urandom, near_point(xs), near_point(ys));
        endcase
      end
      wait_drained();
    end

    repeat (300) @(posedge clk_i);
    if (errors == 0 && expected_rsps.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
